>>> hw/rtl/blf_pkg.sv
`default_nettype none

package blf_pkg;

    // brightness resolution
    localparam int LEVEL_BITS = 8;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

    // field widths
    localparam int MODE_W    = 2;
    localparam int RATE_W    = 16;
    localparam int REFRESH_W = 10;
    localparam int STATE_W   = 2;

    // beat packing
    localparam int S_TDATA_W = ((MODE_W + RATE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((LEVEL_BITS + STATE_W + 7) / 8) * 8;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_REFRESH = 3'd0;

    // reset values
    localparam logic [RATE_W-1:0]    PERIOD_RESET  = 16'd1000;
    localparam logic [REFRESH_W-1:0] REFRESH_RESET = 10'd10;

    // divider sizing
    localparam int SQ_W      = 2 * RATE_W;
    localparam int NUM_W     = SQ_W + LEVEL_BITS;
    localparam int DIV_CNT_W = $clog2(LEVEL_BITS);

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // mode field codes
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;

    // led_state codes
    localparam logic [STATE_W-1:0] LED_OFF   = 2'd0;
    localparam logic [STATE_W-1:0] LED_ON    = 2'd1;
    localparam logic [STATE_W-1:0] LED_BLINK = 2'd2;

    // decoded operations
    typedef logic [2:0] op_code_t;
    localparam op_code_t OP_TICK  = 3'd0;
    localparam op_code_t OP_OFF   = 3'd1;
    localparam op_code_t OP_ON    = 3'd2;
    localparam op_code_t OP_BLINK = 3'd3;
    localparam op_code_t OP_NONE  = 3'd4;

    typedef struct packed {
        op_code_t          op;
        logic [RATE_W-1:0] rate;
    } blf_op_t;

    typedef struct packed {
        logic    valid;
        blf_op_t item;
    } blf_queue_t;

endpackage

`default_nettype wire

>>> hw/rtl/blf_front.sv
`default_nettype none

module blf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [blf_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    output blf_pkg::blf_queue_t                q_head,
    input  wire logic                          q_pop
);

    blf_pkg::blf_op_t                  entry_reg [blf_pkg::QUEUE_DEPTH];
    logic [blf_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [blf_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [blf_pkg::QCNT_W-1:0]        count_reg, count_next;
    blf_pkg::blf_op_t                  decoded;
    logic [blf_pkg::MODE_W-1:0]        mode;
    logic [blf_pkg::RATE_W-1:0]        rate;
    logic                              push;
    logic                              pop;

    assign mode = s_tdata[blf_pkg::MODE_W-1:0];
    assign rate = s_tdata[blf_pkg::MODE_W +: blf_pkg::RATE_W];

    // classify the beat; a zero period becomes one
    always_comb
    begin
        decoded.rate = (rate == '0) ? blf_pkg::RATE_W'(1) : rate;
        if (!s_tuser)
        begin
            decoded.op = blf_pkg::OP_TICK;
        end
        else
        begin
            unique case (mode)
                blf_pkg::MODE_OFF:   decoded.op = blf_pkg::OP_OFF;
                blf_pkg::MODE_ON:    decoded.op = blf_pkg::OP_ON;
                blf_pkg::MODE_BLINK: decoded.op = blf_pkg::OP_BLINK;
                default:             decoded.op = blf_pkg::OP_NONE;
            endcase
        end
    end

    assign s_tready = (count_reg != blf_pkg::QCNT_W'(blf_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (count_reg != '0);

    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == blf_pkg::QPTR_W'(blf_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == blf_pkg::QPTR_W'(blf_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/blf_back.sv
`default_nettype none

module blf_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire blf_pkg::blf_queue_t             q_head,
    output logic                                 q_pop,
    input  wire logic [blf_pkg::REFRESH_W-1:0]   refresh_ms,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [blf_pkg::LEVEL_BITS-1:0]       out_level,
    output logic [blf_pkg::STATE_W-1:0]          out_state
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_SCALE  = 2'd2;
    localparam logic [1:0] ST_DIV    = 2'd3;

    localparam int LB = blf_pkg::LEVEL_BITS;
    localparam int RW = blf_pkg::RATE_W;

    logic [1:0]                         fsm_reg, fsm_next;
    logic                               blinking_reg, blinking_next;
    logic                               lit_reg, lit_next;
    logic [RW-1:0]                      period_reg, period_next;
    logic [RW-1:0]                      phase_reg, phase_next;
    logic [blf_pkg::REFRESH_W-1:0]      refresh_cnt_reg, refresh_cnt_next;
    logic [LB-1:0]                      bright_reg, bright_next;
    logic [blf_pkg::SQ_W-1:0]           x_reg, x_next;
    logic [blf_pkg::SQ_W-1:0]           y_reg, y_next;
    logic [blf_pkg::NUM_W-1:0]          rem_reg, rem_next;
    logic [blf_pkg::NUM_W-1:0]          div_reg, div_next;
    logic [LB-1:0]                      quo_reg, quo_next;
    logic [blf_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                               out_valid_reg, out_valid_next;
    logic [LB-1:0]                      out_level_reg, out_level_next;
    logic [blf_pkg::STATE_W-1:0]        out_state_reg, out_state_next;

    logic                               out_free;
    logic                               load_out;
    logic [RW:0]                        phase_inc;
    logic [RW-1:0]                      phase_wrap;
    logic [blf_pkg::REFRESH_W-1:0]      refresh_inc;
    logic [blf_pkg::REFRESH_W-1:0]      interval;
    logic [RW:0]                        twice_e;
    logic [RW-1:0]                      tri_dist;
    logic [RW-1:0]                      twice_d;
    logic [LB-1:0]                      quo_shift;

    assign out_free    = !out_valid_reg || out_ready;
    assign q_pop       = (fsm_reg == ST_IDLE) && q_head.valid && out_free;

    assign phase_inc   = {1'b0, phase_reg} + 1'b1;
    assign phase_wrap  = (phase_inc == {1'b0, period_reg}) ? '0 : phase_inc[RW-1:0];
    assign refresh_inc = refresh_cnt_reg + 1'b1;
    assign interval    = (refresh_ms == '0) ? blf_pkg::REFRESH_W'(1) : refresh_ms;

    // triangle distance from the phase
    assign twice_e  = {phase_reg, 1'b0};
    assign tri_dist = (twice_e < {1'b0, period_reg}) ? phase_reg : (period_reg - phase_reg);
    assign twice_d  = {tri_dist[RW-2:0], 1'b0};

    assign quo_shift = (rem_reg >= div_reg) ? {quo_reg[LB-2:0], 1'b1} :
                                              {quo_reg[LB-2:0], 1'b0};

    always_comb
    begin
        fsm_next         = fsm_reg;
        blinking_next    = blinking_reg;
        lit_next         = lit_reg;
        period_next      = period_reg;
        phase_next       = phase_reg;
        refresh_cnt_next = refresh_cnt_reg;
        bright_next      = bright_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        load_out         = 1'b0;

        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    load_out = 1'b1;
                    unique case (q_head.item.op)
                        blf_pkg::OP_TICK:
                        begin
                            if (blinking_reg)
                            begin
                                phase_next       = phase_wrap;
                                refresh_cnt_next = refresh_inc;
                                if (refresh_inc >= interval)
                                begin
                                    refresh_cnt_next = '0;
                                    load_out         = 1'b0;
                                    fsm_next         = ST_SQUARE;
                                end
                            end
                        end
                        blf_pkg::OP_OFF:
                        begin
                            blinking_next = 1'b0;
                            lit_next      = 1'b0;
                            bright_next   = '0;
                        end
                        blf_pkg::OP_ON:
                        begin
                            blinking_next = 1'b0;
                            lit_next      = 1'b1;
                            bright_next   = blf_pkg::LEVEL_MAX;
                        end
                        blf_pkg::OP_BLINK:
                        begin
                            if (!(blinking_reg && (period_reg == q_head.item.rate)))
                            begin
                                blinking_next    = 1'b1;
                                period_next      = q_head.item.rate;
                                phase_next       = '0;
                                refresh_cnt_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SQUARE:
            begin
                x_next   = blf_pkg::SQ_W'(twice_d) * blf_pkg::SQ_W'(twice_d);
                y_next   = blf_pkg::SQ_W'(period_reg) * blf_pkg::SQ_W'(period_reg);
                fsm_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                // numerator is level_max * x, divisor starts at y shifted to the top quotient bit
                rem_next = {x_reg, {LB{1'b0}}} - {{LB{1'b0}}, x_reg};
                div_next = {1'b0, y_reg, {(LB-1){1'b0}}};
                quo_next = '0;
                cnt_next = blf_pkg::DIV_CNT_W'(LB - 1);
                fsm_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_reg >= div_reg)
                begin
                    rem_next = rem_reg - div_reg;
                end
                quo_next = quo_shift;
                div_next = div_reg >> 1;
                if (cnt_reg == '0)
                begin
                    bright_next = quo_shift;
                    load_out    = 1'b1;
                    fsm_next    = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        out_level_next = out_level_reg;
        out_state_next = out_state_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_level_next = bright_next;
            out_state_next = blinking_next ? blf_pkg::LED_BLINK :
                             (lit_next ? blf_pkg::LED_ON : blf_pkg::LED_OFF);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= ST_IDLE;
            blinking_reg    <= 1'b0;
            lit_reg         <= 1'b0;
            period_reg      <= blf_pkg::PERIOD_RESET;
            phase_reg       <= '0;
            refresh_cnt_reg <= '0;
            bright_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fsm_reg         <= fsm_next;
            blinking_reg    <= blinking_next;
            lit_reg         <= lit_next;
            period_reg      <= period_next;
            phase_reg       <= phase_next;
            refresh_cnt_reg <= refresh_cnt_next;
            bright_reg      <= bright_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        out_level_reg <= out_level_next;
        out_state_reg <= out_state_next;
    end

    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;
    assign out_state = out_state_reg;

endmodule

`default_nettype wire

>>> hw/rtl/breathing_led_fader.sv
// path: for commands and plain ticks an accepted beat goes into the command queue, then the
//   output register; a tick that recomputes the level first runs squares, scale, 8 divide steps
// throughput: one beat per cycle while the result stream is ready, except recompute ticks,
//   which hold the back end in the restoring divider (one quotient bit per cycle)
// reset: rst_n asynchronous active low; led off, level 0, period 1000 ms,
//   refresh_ms 10, command queue and output register empty
`default_nettype none

module breathing_led_fader (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [blf_pkg::S_TDATA_W-1:0]    s_tdata,   // mode[1:0], rate_ms[17:2], zero pad
    input  wire logic                             s_tuser,   // func: 0 tick, 1 command

    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [blf_pkg::M_TDATA_W-1:0]         m_tdata,   // level[7:0], led_state[9:8], zero pad

    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [blf_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [blf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [blf_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    logic [blf_pkg::REFRESH_W-1:0]   refresh_reg;
    blf_pkg::blf_queue_t             q_head;
    logic                            q_pop;
    logic [blf_pkg::LEVEL_BITS-1:0]  out_level;
    logic [blf_pkg::STATE_W-1:0]     out_state;
    logic                            cfg_write;

    // register file: refresh_ms only, written in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == blf_pkg::ADDR_REFRESH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_reg <= blf_pkg::REFRESH_RESET;
        end
        else if (cfg_write)
        begin
            refresh_reg <= pwdata[blf_pkg::REFRESH_W-1:0];
        end
    end

    assign prdata = (paddr == blf_pkg::ADDR_REFRESH) ?
                    blf_pkg::APB_DATA_W'(refresh_reg) : '0;

    // front end: decode each beat and queue it
    blf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    // back end: led state, phase counters, level divider, output register
    blf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .refresh_ms (refresh_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_level  (out_level),
        .out_state  (out_state)
    );

    // result beat packing, level in the low byte
    assign m_tdata = blf_pkg::M_TDATA_W'({out_state, out_level});

endmodule

`default_nettype wire

>>> hw/rtl/blf_checker.sv
`default_nettype none

module blf_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [blf_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic                             pready
);

    localparam int LB = blf_pkg::LEVEL_BITS;
    localparam int SW = blf_pkg::STATE_W;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // an off led is dark
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[LB +: SW] == blf_pkg::LED_OFF) |-> (m_tdata[LB-1:0] == '0))
        else $error("led off with nonzero level");

    // an on led is at full level
    a_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[LB +: SW] == blf_pkg::LED_ON) |->
        (m_tdata[LB-1:0] == blf_pkg::LEVEL_MAX))
        else $error("led on below full level");

    // configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind breathing_led_fader blf_checker u_blf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

`default_nettype wire

>>> verif/breathing_led_fader_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic [7:0] level;
    logic [1:0] led_state;
} fader_out_t;

class fader_scoreboard;
    logic [9:0]  refresh_ms;
    bit          blinking;
    bit          lit;
    logic [15:0] period;
    logic [15:0] phase;
    logic [9:0]  refresh_cnt;
    logic [7:0]  brightness;
    fader_out_t  level_q[$];
    int          errors;

    function new();
        refresh_ms  = blf_pkg::REFRESH_RESET;
        blinking    = 1'b0;
        lit         = 1'b0;
        period      = blf_pkg::PERIOD_RESET;
        phase       = '0;
        refresh_cnt = '0;
        brightness  = '0;
        errors      = 0;
    endfunction

    function void set_refresh(logic [9:0] value);
        refresh_ms = value;
    endfunction

    function int pending();
        return level_q.size();
    endfunction

    // floor(max * (2d)^2 / r^2) on a triangle of the phase
    function logic [7:0] squared_triangle_level(logic [15:0] e, logic [15:0] r);
        longint unsigned ee;
        longint unsigned rr;
        longint unsigned d;
        longint unsigned num;
        ee = 64'(e);
        rr = (r == 0) ? 64'd1 : 64'(r);
        if (ee >= rr)
            ee = ee % rr;
        d   = (2 * ee < rr) ? ee : rr - ee;
        num = longint'(blf_pkg::LEVEL_MAX) * (2 * d) * (2 * d);
        return 8'((num / (rr * rr)) & longint'(blf_pkg::LEVEL_MAX));
    endfunction

    function void note_beat(bit func, logic [1:0] mode, logic [15:0] rate);
        logic [9:0]  interval;
        logic [15:0] r;
        fader_out_t  exp_out;
        if (!func)
        begin
            if (blinking)
            begin
                interval    = (refresh_ms == 0) ? 10'd1 : refresh_ms;
                r           = (period == 0) ? 16'd1 : period;
                phase       = 16'((17'(phase) + 17'd1) % 17'(r));
                refresh_cnt = refresh_cnt + 10'd1;
                if (refresh_cnt >= interval)
                begin
                    refresh_cnt = '0;
                    brightness  = squared_triangle_level(phase, r);
                end
            end
        end
        else
        begin
            unique case (mode)
                blf_pkg::MODE_OFF:
                begin
                    blinking   = 1'b0;
                    lit        = 1'b0;
                    brightness = '0;
                end
                blf_pkg::MODE_ON:
                begin
                    blinking   = 1'b0;
                    lit        = 1'b1;
                    brightness = blf_pkg::LEVEL_MAX;
                end
                blf_pkg::MODE_BLINK:
                begin
                    r = (rate == 0) ? 16'd1 : rate;
                    if (!(blinking && period == r))
                    begin
                        blinking    = 1'b1;
                        period      = r;
                        phase       = '0;
                        refresh_cnt = '0;
                    end
                end
                default: ;
            endcase
        end
        exp_out.level     = brightness;
        exp_out.led_state = blinking ? blf_pkg::LED_BLINK
                          : (lit ? blf_pkg::LED_ON : blf_pkg::LED_OFF);
        level_q.push_back(exp_out);
    endfunction

    function void check_beat(logic [blf_pkg::M_TDATA_W-1:0] tdata);
        fader_out_t exp_out;
        if (level_q.size() == 0)
        begin
            $display("%0t: unexpected result beat, actual level %0d led_state %0d",
                     $time, tdata[7:0], tdata[9:8]);
            errors++;
            return;
        end
        exp_out = level_q.pop_front();
        if (tdata[7:0] !== exp_out.level)
        begin
            $display("%0t: level mismatch, expected %0d actual %0d",
                     $time, exp_out.level, tdata[7:0]);
            errors++;
        end
        if (tdata[9:8] !== exp_out.led_state)
        begin
            $display("%0t: led_state mismatch, expected %0d actual %0d",
                     $time, exp_out.led_state, tdata[9:8]);
            errors++;
        end
    endfunction
endclass

module breathing_led_fader_tb;

    // unnamed mode code, must be ignored by the block
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam bit FUNC_TICK = 1'b0;
    localparam bit FUNC_CMD  = 1'b1;

    // long receiver hold-off for the pressure phase
    localparam int HOLD_CYCLES = 300;
    // settle time after the last result, longer than a recompute tick
    localparam int DRAIN_CYCLES = 24;
    // generous bound on the whole run
    localparam int CYCLE_LIMIT = 400000;

    localparam int PHASE_ITEMS = 138;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [blf_pkg::S_TDATA_W-1:0]     s_tdata;
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [blf_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [blf_pkg::APB_ADDR_W-1:0]    paddr;
    logic [blf_pkg::APB_DATA_W-1:0]    pwdata;
    logic [blf_pkg::APB_DATA_W-1:0]    prdata;
    logic                              pready;

    // idle percentages read by the sender task and the receiver process
    int send_idle_pct;
    int recv_stall_pct;
    // hold-off requests from the stimulus, served by the receiver
    int hold_asked;
    int cycle_count;

    fader_scoreboard sb = new();

    breathing_led_fader u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run bound, counted on every rising edge
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("breathing_led_fader_tb: done, errors");
                $finish;
            end
        end
    end

    // result side: check accepted beats, then pick the next tready
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_beat(m_tdata);
            // a new hold-off request starts a long stall counted here
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one beat and wait for its handshake; tvalid stays high after
    // acceptance so back-to-back beats never lower and raise it in one step
    task automatic send_beat(input bit func, input logic [1:0] mode,
                             input logic [15:0] rate);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(blf_pkg::S_TDATA_W - 18){1'b0}}, rate, mode};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(func, mode, rate);
    endtask

    // setup then access phase; the register takes the value on the access edge
    task automatic write_refresh(input logic [9:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= blf_pkg::ADDR_REFRESH;
        pwdata  <= blf_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_refresh(value);
    endtask

    // stop offering and let every expected beat come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // a recompute tick may still be in the divider
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly ticks while blinking at short periods, so the level keeps moving;
    // the rest are re-blinks, on/off, odd periods and unused mode codes
    task automatic run_phase(input logic [9:0] refresh, input int send_pct,
                             input int recv_pct, input bit hold_off);
        int          pick;
        int          sub;
        logic [15:0] rate;
        write_refresh(refresh);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold_off)
            hold_asked++;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                send_beat(FUNC_TICK, 2'($urandom_range(3)), 16'($urandom));
            else if (pick < 89)
            begin
                sub = $urandom_range(9);
                if (sub < 6)
                    rate = 16'($urandom_range(64, 1));
                else if (sub < 8)
                    rate = sb.period;
                else if (sub < 9)
                    rate = '0;
                else
                    rate = 16'($urandom);
                send_beat(FUNC_CMD, blf_pkg::MODE_BLINK, rate);
            end
            else if (pick < 93)
                send_beat(FUNC_CMD, blf_pkg::MODE_ON, 16'($urandom));
            else if (pick < 97)
                send_beat(FUNC_CMD, blf_pkg::MODE_OFF, 16'($urandom));
            else
                send_beat(FUNC_CMD, MODE_UNUSED, 16'($urandom));
        end
        drain();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asked     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset refresh interval of 10
        // tick while off carries junk mode and rate
        send_beat(FUNC_TICK, MODE_UNUSED, 16'hFFFF);
        // unused mode code changes nothing
        send_beat(FUNC_CMD, MODE_UNUSED, 16'h0000);
        send_beat(FUNC_CMD, blf_pkg::MODE_ON, 16'h0000);
        // tick while lit holds the full level
        send_beat(FUNC_TICK, blf_pkg::MODE_OFF, 16'h0000);
        // zero period clamps to one; lit flag is left as it was
        send_beat(FUNC_CMD, blf_pkg::MODE_BLINK, 16'h0000);
        // same period while blinking is ignored
        send_beat(FUNC_CMD, blf_pkg::MODE_BLINK, 16'h0001);
        // first recompute on the tenth tick
        for (int i = 0; i < 10; i++)
            send_beat(FUNC_TICK, blf_pkg::MODE_BLINK, 16'h5555);
        send_beat(FUNC_CMD, blf_pkg::MODE_BLINK, 16'hFFFF);
        send_beat(FUNC_CMD, blf_pkg::MODE_BLINK, 16'hFFFF);
        send_beat(FUNC_CMD, blf_pkg::MODE_OFF, 16'hAAAA);
        send_beat(FUNC_TICK, blf_pkg::MODE_ON, 16'h0000);
        // leave it blinking with a partial refresh count, so the next
        // phase lowers the interval below the running count
        send_beat(FUNC_CMD, blf_pkg::MODE_BLINK, 16'h0004);
        for (int i = 0; i < 3; i++)
            send_beat(FUNC_TICK, blf_pkg::MODE_OFF, 16'h0000);
        drain();

        // random phases over refresh settings and idling patterns
        run_phase(10'd1,    0,  0,  1'b0);
        run_phase(10'd0,    56, 0,  1'b0);
        run_phase(10'd5,    0,  56, 1'b0);
        run_phase(10'd1023, 37, 37, 1'b0);
        // receiver holds off while the sender keeps offering
        run_phase(10'd2,    0,  0,  1'b1);
        run_phase(10'd7,    37, 37, 1'b0);

        if (sb.errors == 0)
            $display("breathing_led_fader_tb: done, clean");
        else
            $display("breathing_led_fader_tb: done, errors");
        $finish;
    end

endmodule

>>> breathing_led_fader.f
hw/rtl/blf_pkg.sv
hw/rtl/blf_front.sv
hw/rtl/blf_back.sv
hw/rtl/breathing_led_fader.sv
hw/rtl/blf_checker.sv
verif/breathing_led_fader_tb.sv
